// ===== hw/rtl/gfxn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfxn_pkg
// Shared widths, register indexes and reset values for the GF(2) x^n mod p(x)
// block.
// ----------------------------------------------------------------------------
package gfxn_pkg;

    localparam int POLY_W     = 64;
    localparam int DEG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int TOP_W      = 6;

    typedef logic [POLY_W-1:0] poly_t;
    typedef logic [DEG_W-1:0]  deg_t;

    localparam logic [CFG_IDX_W-1:0] REG_POLY_LOW_TERMS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE    = 1'b1;

    localparam poly_t POLY_LOW_RESET = 64'h0000_0000_04C1_1DB7;
    localparam deg_t  POLY_DEG_RESET = 7'd32;
    localparam deg_t  POLY_DEG_MAX   = 7'd64;
    localparam deg_t  POLY_DEG_MIN   = 7'd1;

endpackage

// ===== hw/rtl/gf2_x_pow_n_mod_poly.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_x_pow_n_mod_poly
// x^n mod p(x) over GF(2) with the low 64 bits of the quotient, one quotient
// bit per clock through a shared shift-and-XOR step.
// ----------------------------------------------------------------------------
// The result is registered: for n below the degree it is x^n itself, otherwise
//   the shift/XOR reduction step runs once for each power of x above the degree.
// Throughput: one item at a time; the next input is taken in the cycle the
//   result transfers.
// Reset: rst_n clears the sequencer and loads p(x) = x^32 + 0x04C11DB7.
module gf2_x_pow_n_mod_poly
    import gfxn_pkg::*;
#(
    parameter int EXPONENT_BITS = 12
)
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [POLY_W-1:0]        cfg_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [EXPONENT_BITS-1:0] exponent,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [POLY_W-1:0]        remainder,
    output logic [POLY_W-1:0]        quotient_low
);

    localparam int CMP_W = (EXPONENT_BITS > DEG_W) ? EXPONENT_BITS : DEG_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]               state_reg, state_next;
    poly_t                    poly_low_reg;
    deg_t                     poly_deg_reg;
    poly_t                    rem_reg, rem_next;
    poly_t                    quo_reg, quo_next;
    logic [EXPONENT_BITS-1:0] cnt_reg, cnt_next;

    deg_t                     deg_eff;
    logic [TOP_W-1:0]         top_bit;
    poly_t                    mask;
    poly_t                    low_masked;
    logic                     high;
    logic                     in_xfer;
    logic [CMP_W-1:0]         n_ext;
    logic [CMP_W-1:0]         deg_ext;
    logic [CMP_W-1:0]         steps;

    // Effective degree, clamped to 1..64
    always_comb
    begin
        if (poly_deg_reg < POLY_DEG_MIN)
            deg_eff = POLY_DEG_MIN;
        else if (poly_deg_reg > POLY_DEG_MAX)
            deg_eff = POLY_DEG_MAX;
        else
            deg_eff = poly_deg_reg;
    end

    assign top_bit    = TOP_W'(deg_eff - POLY_DEG_MIN);
    assign mask       = ~(~poly_t'(0) << deg_eff);
    assign low_masked = poly_low_reg & mask;
    assign high       = rem_reg[top_bit];

    assign n_ext   = CMP_W'(exponent);
    assign deg_ext = CMP_W'(deg_eff);
    assign steps   = n_ext - deg_ext;

    assign in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_ready);
    assign in_xfer   = in_valid && in_ready;
    assign out_valid = (state_reg == ST_DONE);

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                if (state_reg == ST_DONE && out_ready)
                    state_next = ST_IDLE;
                if (in_xfer)
                begin
                    if (n_ext < deg_ext)
                    begin
                        // below the degree: x^n itself
                        rem_next   = poly_t'(1) << exponent[TOP_W-1:0];
                        quo_next   = '0;
                        cnt_next   = '0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rem_next   = low_masked;
                        quo_next   = poly_t'(1);
                        cnt_next   = steps[EXPONENT_BITS-1:0];
                        state_next = (steps == '0) ? ST_DONE : ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                rem_next = ((rem_reg << 1) & mask) ^ (high ? low_masked : '0);
                quo_next = {quo_reg[POLY_W-2:0], high};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == EXPONENT_BITS'(1))
                    state_next = ST_DONE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            poly_low_reg <= POLY_LOW_RESET;
            poly_deg_reg <= POLY_DEG_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_POLY_LOW_TERMS: poly_low_reg <= cfg_data;
                    REG_POLY_DEGREE:    poly_deg_reg <= cfg_data[DEG_W-1:0];
                    default:            poly_low_reg <= poly_low_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign remainder    = rem_reg;
    assign quotient_low = quo_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !in_ready)
        else $error("input taken while reducing");

    a_run_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (cnt_reg != '0))
        else $error("step counter empty in run state");

    a_rem_masked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((remainder & ~mask) == '0))
        else $error("remainder has bits at or above the degree");

    a_xfer_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg != ST_IDLE))
        else $error("input transfer did not start work");

endmodule
